@@ src/wpsp_pkg.sv @@
package wpsp_pkg;

	localparam logic [4:0] HDR_LEN  = 5'd22;
	localparam logic [9:0] CHAN_MAX = 10'd14;
	localparam logic [3:0] CHAN_RST = 4'd6;

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_1 = 8'h31;
	localparam logic [7:0] CH_2 = 8'h32;
	localparam logic [7:0] CH_3 = 8'h33;
	localparam logic [7:0] CH_9 = 8'h39;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;

	localparam logic [1:0] AUTH_NONE = 2'd0;
	localparam logic [1:0] AUTH_ONE  = 2'd1;
	localparam logic [1:0] AUTH_TWO  = 2'd2;
	localparam logic [1:0] AUTH_MISC = 2'd3;

	localparam logic [1:0] NET_ZERO  = 2'd0;
	localparam logic [1:0] NET_ONE   = 2'd1;
	localparam logic [1:0] NET_OTHER = 2'd2;

	// Payload field order; the field index is also the output tag.
	localparam logic [2:0] FLD_KEY     = 3'd1;
	localparam logic [2:0] FLD_GATEWAY = 3'd4;
	localparam logic [2:0] FLD_LAST    = 3'd7;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		U_NET,
		U_CHAN,
		U_AUTH,
		U_KIDX,
		U_IPM,
		U_LEN
	} unit_t;

	typedef struct packed {
		unit_t      unit;
		logic [2:0] lidx;
		logic       first;
		logic       lastp;
	} hdr_slot_t;

	typedef struct packed {
		logic       last_result;
		logic       kind;
		logic [6:0] key_length;
		logic [7:0] ssid_length;
		logic       ip_mode;
		logic [1:0] key_index;
		logic [1:0] auth_type;
		logic [3:0] channel;
		logic [1:0] network_type;
		logic [1:0] status;
		logic [7:0] data_byte;
		logic [2:0] field_tag;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} fifo_wr_t;

	// Header layout: which field each header position belongs to, and whether
	// it opens or closes that field.
	function automatic hdr_slot_t hdr_slot(input logic [4:0] pos);
		hdr_slot_t s;
		unique case (pos)
			5'd0:  s = '{U_NET,  3'd0, 1'b1, 1'b1};
			5'd1:  s = '{U_CHAN, 3'd0, 1'b1, 1'b0};
			5'd2:  s = '{U_CHAN, 3'd0, 1'b0, 1'b1};
			5'd3:  s = '{U_AUTH, 3'd0, 1'b1, 1'b1};
			5'd4:  s = '{U_KIDX, 3'd0, 1'b1, 1'b1};
			5'd5:  s = '{U_IPM,  3'd0, 1'b1, 1'b1};
			5'd6:  s = '{U_LEN,  3'd0, 1'b1, 1'b0};
			5'd7:  s = '{U_LEN,  3'd0, 1'b0, 1'b0};
			5'd8:  s = '{U_LEN,  3'd0, 1'b0, 1'b1};
			5'd9:  s = '{U_LEN,  3'd1, 1'b1, 1'b0};
			5'd10: s = '{U_LEN,  3'd1, 1'b0, 1'b1};
			5'd11: s = '{U_LEN,  3'd2, 1'b1, 1'b0};
			5'd12: s = '{U_LEN,  3'd2, 1'b0, 1'b1};
			5'd13: s = '{U_LEN,  3'd3, 1'b1, 1'b0};
			5'd14: s = '{U_LEN,  3'd3, 1'b0, 1'b1};
			5'd15: s = '{U_LEN,  3'd4, 1'b1, 1'b0};
			5'd16: s = '{U_LEN,  3'd4, 1'b0, 1'b1};
			5'd17: s = '{U_LEN,  3'd5, 1'b1, 1'b1};
			5'd18: s = '{U_LEN,  3'd6, 1'b1, 1'b0};
			5'd19: s = '{U_LEN,  3'd6, 1'b0, 1'b1};
			5'd20: s = '{U_LEN,  3'd7, 1'b1, 1'b0};
			5'd21: s = '{U_LEN,  3'd7, 1'b0, 1'b1};
			default: s = '{U_NET, 3'd0, 1'b0, 1'b0};
		endcase
		return s;
	endfunction

	// Channel commit: out-of-range values fall back to the default channel.
	function automatic logic [3:0] chan_pick(input logic [9:0] v, input logic [3:0] dflt);
		logic [3:0] r;
		if (v == 10'd0 || v > CHAN_MAX) begin
			r = dflt;
		end else begin
			r = v[3:0];
		end
		return r;
	endfunction

endpackage

@@ src/wpsp_out_fifo.sv @@
module wpsp_out_fifo
	import wpsp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  fifo_wr_t wr,
	output logic     room,
	output logic     out_valid,
	input  logic     out_ready,
	output res_t     out_res
);

	res_t               mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pop;

	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_ptr_q];
	assign pop       = out_valid & out_ready;
	// Room for two entries, since one beat in can produce two results.
	assign room      = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(wr.cnt);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q    <= cnt_q + CNT_W'(wr.cnt) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= wr.r0;
		end
		if (wr.cnt == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= wr.r1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("output queue overflow");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		wr.cnt != 2'd0 |-> cnt_q <= CNT_W'(FIFO_DEPTH - 2))
		else $error("push into a queue without room for two entries");

endmodule

@@ src/wifi_provisioning_string_parser.sv @@
// A result beat is written into the output queue when the input beat that causes it is accepted.
// Throughput: one input byte per cycle while the output queue has room for two results; a
// final byte that also carries a payload byte yields two results, which leave the queue one after the other.
// The rate is set by the single decode step per byte and the one-result-per-cycle output port.
// Reset (arst_n low, asynchronous) empties the output queue, clears the parser state and
// sets the default channel register to 6.
module wifi_provisioning_string_parser
	import wpsp_pkg::*;
#(
	parameter int COUNT_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: default channel register.
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  logic        s_axis_tlast,   // last_byte
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] field_tag, [10:3] data_byte, [12:11] status, [14:13] network_type,
	// [18:15] channel, [20:19] auth_type, [22:21] key_index, [23] ip_mode,
	// [31:24] ssid_length, [38:32] key_length, [39] zero pad
	output logic [39:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser,   // [0] kind
	output logic        m_axis_tlast    // last_result
);

	localparam int CMP_W = (COUNT_BITS > 12) ? COUNT_BITS : 12;

	// Configuration register.
	logic [3:0] dflt_q;

	// Parser state. The header fields live in separate registers; lengths in a
	// small table, and total_q keeps the running sum of committed lengths so the
	// end-of-string check needs only one add and compare.
	logic [4:0]            hdr_pos_q;
	logic [COUNT_BITS-1:0] byte_cnt_q;
	logic [9:0]            acc_q;
	logic                  stop_q;
	logic [1:0]            nt_q;
	logic [3:0]            ch_q;
	logic [1:0]            au_q;
	logic [1:0]            ki_q;
	logic                  im_q;
	logic [7:0]            len_q [8];
	logic [10:0]           total_q;
	logic [2:0]            pay_fld_q;
	logic [7:0]            pay_rem_q;

	// Next-state values.
	logic [4:0]            hdr_pos_n;
	logic [COUNT_BITS-1:0] byte_cnt_n;
	logic [9:0]            acc_n;
	logic                  stop_n;
	logic [1:0]            nt_n;
	logic [3:0]            ch_n;
	logic [1:0]            au_n;
	logic [1:0]            ki_n;
	logic                  im_n;
	logic [7:0]            len_n [8];
	logic [10:0]           total_n;
	logic [2:0]            pay_fld_n;
	logic [7:0]            pay_rem_n;

	logic       s_acc;
	logic [7:0] c;
	logic       in_hdr;
	logic       is_digit;
	hdr_slot_t  slot;
	hdr_slot_t  vslot;
	logic [9:0] acc_base;
	logic       stop_base;
	logic [12:0] acc_mul;
	logic [2:0] srch_fld;
	logic [7:0] srch_rem;
	logic       emit_pay;

	// Values shown by the summary when the string ends inside the header.
	logic       short_str;
	logic [9:0] acc_v;
	logic [3:0] ch_v;
	logic [1:0] au_v;
	logic [7:0] l0_v;
	logic [7:0] l1_v;
	logic [CMP_W-1:0] sum_len;
	logic [1:0] st;

	res_t     pay_res;
	res_t     sum_res;
	fifo_wr_t wr;
	logic     fifo_room;
	res_t     out_res;

	assign s_acc    = s_axis_tvalid & s_axis_tready;
	assign c        = s_axis_tdata;
	assign in_hdr   = (hdr_pos_q < HDR_LEN);
	assign is_digit = (c >= CH_0) && (c <= CH_9);
	assign slot     = hdr_slot(hdr_pos_q);

	always_comb begin
		hdr_pos_n  = hdr_pos_q;
		byte_cnt_n = (byte_cnt_q != '1) ? byte_cnt_q + COUNT_BITS'(1) : byte_cnt_q;
		acc_n      = acc_q;
		stop_n     = stop_q;
		nt_n       = nt_q;
		ch_n       = ch_q;
		au_n       = au_q;
		ki_n       = ki_q;
		im_n       = im_q;
		len_n      = len_q;
		total_n    = total_q;
		pay_fld_n  = pay_fld_q;
		pay_rem_n  = pay_rem_q;
		emit_pay   = 1'b0;
		acc_base   = slot.first ? 10'd0 : acc_q;
		stop_base  = slot.first ? 1'b0 : stop_q;
		acc_mul    = {acc_base, 3'b000} + {2'b00, acc_base, 1'b0} + {9'd0, c[3:0]};

		// Search for the next payload field that still has bytes, skipping empty ones.
		srch_fld = FLD_LAST;
		srch_rem = 8'd0;
		for (int j = 7; j >= 1; j--) begin
			if (3'(j) > pay_fld_q && len_q[3'(j)] != 8'd0) begin
				srch_fld = 3'(j);
				srch_rem = len_q[3'(j)];
			end
		end
		if (pay_rem_q != 8'd0) begin
			srch_fld = pay_fld_q;
			srch_rem = pay_rem_q;
		end

		if (in_hdr) begin
			unique case (slot.unit)
				U_NET: begin
					nt_n = (c == CH_0) ? NET_ZERO : ((c == CH_1) ? NET_ONE : NET_OTHER);
				end
				U_AUTH: begin
					au_n = (c == CH_0 || c == CH_1) ? AUTH_ONE :
						((c == CH_2) ? AUTH_TWO : AUTH_MISC);
				end
				U_KIDX: begin
					if (au_q == AUTH_ONE && c >= CH_0 && c <= CH_3) begin
						ki_n = c[1:0];
					end
				end
				U_IPM: begin
					if (c == CH_0 || c == CH_1) begin
						im_n = c[0];
					end
				end
				U_CHAN, U_LEN: begin
					if (!stop_base && is_digit) begin
						acc_n  = acc_mul[9:0];
						stop_n = stop_base;
					end else begin
						acc_n  = acc_base;
						stop_n = 1'b1;
					end
					if (slot.lastp) begin
						if (slot.unit == U_CHAN) begin
							ch_n = chan_pick(acc_n, dflt_q);
						end else begin
							len_n[slot.lidx] = acc_n[7:0];
							total_n = total_q + {3'd0, acc_n[7:0]};
							if (slot.lidx == FLD_KEY && acc_n[7:0] == 8'd0) begin
								au_n = AUTH_NONE;
							end
						end
					end
				end
				default: begin
				end
			endcase
			hdr_pos_n = hdr_pos_q + 5'd1;
			if (hdr_pos_n == HDR_LEN) begin
				pay_fld_n = 3'd0;
				pay_rem_n = len_q[0];
			end
		end else begin
			pay_fld_n = srch_fld;
			if (srch_rem != 8'd0) begin
				pay_rem_n = srch_rem - 8'd1;
				emit_pay  = (srch_fld <= FLD_KEY) || (srch_fld <= FLD_GATEWAY && im_q);
			end else begin
				pay_rem_n = 8'd0;
			end
		end
	end

	// A string that ends inside the header decodes one extra zero byte at the
	// next position; the field holding it is closed with what it has so far.
	assign vslot = hdr_slot(hdr_pos_n);

	always_comb begin
		short_str = (hdr_pos_q < HDR_LEN - 5'd1);
		acc_v = vslot.first ? 10'd0 : acc_n;
		ch_v  = ch_n;
		au_v  = au_n;
		l0_v  = len_n[0];
		l1_v  = len_n[1];
		if (short_str) begin
			unique case (vslot.unit)
				U_CHAN: ch_v = chan_pick(acc_v, dflt_q);
				U_AUTH: au_v = AUTH_MISC;
				U_LEN: begin
					if (vslot.lidx == 3'd0) begin
						l0_v = acc_v[7:0];
					end
					if (vslot.lidx == FLD_KEY) begin
						l1_v = acc_v[7:0];
						if (acc_v[7:0] == 8'd0) begin
							au_v = AUTH_NONE;
						end
					end
				end
				default: begin
				end
			endcase
		end
		sum_len = CMP_W'(HDR_LEN) + CMP_W'(total_n);
		if (short_str) begin
			st = ST_SHORT;
		end else if (sum_len == CMP_W'(byte_cnt_n)) begin
			st = ST_OK;
		end else begin
			st = ST_MISMATCH;
		end
	end

	always_comb begin
		pay_res             = '0;
		pay_res.kind        = KIND_PAYLOAD;
		pay_res.field_tag   = srch_fld;
		pay_res.data_byte   = c;
		pay_res.last_result = ~s_axis_tlast;

		sum_res              = '0;
		sum_res.kind         = KIND_SUMMARY;
		sum_res.status       = st;
		sum_res.network_type = nt_n;
		sum_res.channel      = ch_v;
		sum_res.auth_type    = au_v;
		sum_res.key_index    = ki_n;
		sum_res.ip_mode      = im_n;
		sum_res.ssid_length  = l0_v;
		sum_res.key_length   = l1_v[6:0];
		sum_res.last_result  = 1'b1;

		wr = '0;
		if (s_acc) begin
			if (emit_pay && s_axis_tlast) begin
				wr.cnt = 2'd2;
				wr.r0  = pay_res;
				wr.r1  = sum_res;
			end else if (emit_pay) begin
				wr.cnt = 2'd1;
				wr.r0  = pay_res;
			end else if (s_axis_tlast) begin
				wr.cnt = 2'd1;
				wr.r0  = sum_res;
			end
		end
	end

	// State update. The last byte of a string returns the parser state to its
	// reset value, with the channel taken from the register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q     <= CHAN_RST;
			hdr_pos_q  <= '0;
			byte_cnt_q <= '0;
			acc_q      <= '0;
			stop_q     <= 1'b0;
			nt_q       <= '0;
			ch_q       <= CHAN_RST;
			au_q       <= '0;
			ki_q       <= '0;
			im_q       <= 1'b0;
			len_q      <= '{default: 8'd0};
			total_q    <= '0;
			pay_fld_q  <= '0;
			pay_rem_q  <= '0;
		end else begin
			if (cfg_we) begin
				dflt_q <= cfg_wdata;
			end
			if (s_acc) begin
				if (s_axis_tlast) begin
					hdr_pos_q  <= '0;
					byte_cnt_q <= '0;
					acc_q      <= '0;
					stop_q     <= 1'b0;
					nt_q       <= '0;
					ch_q       <= dflt_q;
					au_q       <= '0;
					ki_q       <= '0;
					im_q       <= 1'b0;
					len_q      <= '{default: 8'd0};
					total_q    <= '0;
					pay_fld_q  <= '0;
					pay_rem_q  <= '0;
				end else begin
					hdr_pos_q  <= hdr_pos_n;
					byte_cnt_q <= byte_cnt_n;
					acc_q      <= acc_n;
					stop_q     <= stop_n;
					nt_q       <= nt_n;
					ch_q       <= ch_n;
					au_q       <= au_n;
					ki_q       <= ki_n;
					im_q       <= im_n;
					len_q      <= len_n;
					total_q    <= total_n;
					pay_fld_q  <= pay_fld_n;
					pay_rem_q  <= pay_rem_n;
				end
			end
		end
	end

	// The output queue decouples the two sides: a new byte is taken whenever
	// the queue has room for the two results it may cause.
	wpsp_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.room      (fifo_room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign s_axis_tready = fifo_room;
	assign m_axis_tdata  = {1'b0, out_res.key_length, out_res.ssid_length, out_res.ip_mode,
		out_res.key_index, out_res.auth_type, out_res.channel, out_res.network_type,
		out_res.status, out_res.data_byte, out_res.field_tag};
	assign m_axis_tuser  = out_res.kind;
	assign m_axis_tlast  = out_res.last_result;

	a_string_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_axis_tlast |=> hdr_pos_q == 5'd0 && byte_cnt_q == '0 && total_q == '0)
		else $error("parser state not cleared after the final byte");

	a_summary_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_axis_tlast |-> wr.cnt != 2'd0)
		else $error("final byte produced no summary");

	a_hdr_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_pos_q <= HDR_LEN)
		else $error("header position past the header");

	a_payload_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		pay_rem_q != 8'd0 |-> hdr_pos_q == HDR_LEN)
		else $error("payload bytes pending while the header is still open");

endmodule
